>>> hdl/adl32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 checksum package
// Shared widths, modulus constants, control struct and the single-step
// modular reduction used across the datapath.
// ----------------------------------------------------------------------------
package adl32_pkg;

    localparam int DATA_W             = 64;
    localparam int DATA_BYTES         = DATA_W / 8;
    localparam int COUNT_W            = 4;
    localparam int CHECKSUM_W         = 32;
    localparam int HALF_W             = 16;
    localparam int BYTES_PER_WORD_DEF = 8;

    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    // 2^16 mod 65521, used to fold the upper bits back in
    localparam logic [4:0]  ADLER_FOLD = 5'd15;

    localparam logic [HALF_W-1:0] START_LO_RST = 16'd1;
    localparam logic [HALF_W-1:0] START_HI_RST = 16'd0;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_ctl;

    // Reduce a value below twice the modulus by one conditional subtract
    function automatic logic [HALF_W-1:0] mod_once(input logic [16:0] v);
        logic [16:0] d;
        d = v - ADLER_MOD;
        return (v >= ADLER_MOD) ? d[HALF_W-1:0] : v[HALF_W-1:0];
    endfunction

endpackage

>>> hdl/adl32_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 input channel
// Valid/ready channel carrying one data word, its byte count and framing.
// ----------------------------------------------------------------------------
interface adl32_in_if;
    import adl32_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    data_word;
    logic [COUNT_W-1:0]   byte_count;
    logic                 first;
    logic                 last;

    modport source (output valid, data_word, byte_count, first, last, input ready);
    modport sink   (input valid, data_word, byte_count, first, last, output ready);
endinterface

>>> hdl/adl32_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 output channel
// Valid/ready channel carrying one finished checksum.
// ----------------------------------------------------------------------------
interface adl32_out_if;
    import adl32_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHECKSUM_W-1:0] checksum;

    modport source (output valid, checksum, input ready);
    modport sink   (input valid, checksum, output ready);
endinterface

>>> hdl/adler32_stream_checksum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 stream checksum
// Running Adler-32 over a word stream, one word of up to eight bytes per
// transaction, emitting high<<16|low on the closing transaction.
// ----------------------------------------------------------------------------
// The block takes one input transaction every clock cycle while ready, and
// returns a message's checksum through the lane, merge and accumulator
// registers after its last transaction is accepted. Input ready drops only
// while a finished checksum is held on the output and not taken; the three
// stages then hold together. The rate is set by the running-sum feedback: n
// times the old low sum, a fold of 2^16 back as 15, and one subtract of 65521.
// The start value may be written at any time the block is idle; halves at or
// above 65521 are reduced once on write. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module adler32_stream_checksum_top #(
    parameter int BYTES_PER_WORD = adl32_pkg::BYTES_PER_WORD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [adl32_pkg::CHECKSUM_W-1:0] i_cfg_wr_data,
    adl32_in_if.sink                         i_in_chan,
    adl32_out_if.source                      o_out_chan
);
    import adl32_pkg::*;

    localparam int NW    = $clog2(BYTES_PER_WORD + 1);
    localparam int CMP_W = (NW > COUNT_W) ? NW : COUNT_W;

    // Global advance: every stage moves when the output slot is free or
    // being emptied this cycle.
    logic                            w_advance;
    logic                            w_out_valid;
    logic [CHECKSUM_W-1:0]           w_out_checksum;

    // Saturated byte count of the incoming transaction
    logic [CMP_W-1:0]                w_cnt_ext;
    logic [CMP_W-1:0]                w_cnt_sat;
    logic [NW-1:0]                   w_cnt;
    t_ctl                            w_in_ctl;

    // Stage A: lane outputs plus control
    t_ctl                            r_a_ctl;
    logic [NW-1:0]                   r_a_n;
    logic [BYTES_PER_WORD-1:0][7:0]  w_lane_bytes;
    logic [BYTES_PER_WORD-1:0][NW+7:0] w_lane_wgts;

    // Stage B: merged sums
    t_ctl                            w_m_ctl;
    logic [NW-1:0]                   w_m_n;
    logic [HALF_W-1:0]               w_m_sum_lo;
    logic [HALF_W-1:0]               w_m_sum_wt;

    assign w_advance       = !w_out_valid || o_out_chan.ready;
    assign i_in_chan.ready = w_advance;

    // Clamp the count to the lane count
    assign w_cnt_ext = CMP_W'(i_in_chan.byte_count);
    assign w_cnt_sat = (w_cnt_ext > CMP_W'(BYTES_PER_WORD)) ? CMP_W'(BYTES_PER_WORD)
                                                            : w_cnt_ext;
    assign w_cnt     = w_cnt_sat[NW-1:0];

    assign w_in_ctl.valid = i_in_chan.valid;
    assign w_in_ctl.first = i_in_chan.first;
    assign w_in_ctl.last  = i_in_chan.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (w_advance) begin
            r_a_ctl <= w_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_a_n <= w_cnt;
        end
    end

    // One lane per byte position; positions past the data word read as zero
    for (genvar g = 0; g < BYTES_PER_WORD; g++) begin : g_lane
        logic [7:0] w_src_byte;

        if (g < DATA_BYTES) begin : g_data
            assign w_src_byte = i_in_chan.data_word[8*g +: 8];
        end else begin : g_pad
            assign w_src_byte = 8'h00;
        end

        adl32_lane #(
            .BYTES_PER_WORD (BYTES_PER_WORD),
            .LANE_IDX       (g)
        ) u_lane (
            .i_clk     (i_clk),
            .i_advance (w_advance),
            .i_byte    (w_src_byte),
            .i_n       (w_cnt),
            .o_byte    (w_lane_bytes[g]),
            .o_wgt     (w_lane_wgts[g])
        );
    end

    adl32_merge #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_ctl     (r_a_ctl),
        .i_n       (r_a_n),
        .i_bytes   (w_lane_bytes),
        .i_wgts    (w_lane_wgts),
        .o_ctl     (w_m_ctl),
        .o_n       (w_m_n),
        .o_sum_lo  (w_m_sum_lo),
        .o_sum_wt  (w_m_sum_wt)
    );

    adl32_accum #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctl         (w_m_ctl),
        .i_n           (w_m_n),
        .i_sum_lo      (w_m_sum_lo),
        .i_sum_wt      (w_m_sum_wt),
        .o_valid       (w_out_valid),
        .o_checksum    (w_out_checksum)
    );

    assign o_out_chan.valid    = w_out_valid;
    assign o_out_chan.checksum = w_out_checksum;

    // A closing transaction leaving the merge stage must show up on the output
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_m_ctl.valid && w_m_ctl.last) |=> o_out_chan.valid)
        else $error("closing transaction produced no checksum");

    // Both halves of an emitted checksum are fully reduced
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_chan.valid |-> ((o_out_chan.checksum[15:0] < 16'(ADLER_MOD)) &&
                              (o_out_chan.checksum[31:16] < 16'(ADLER_MOD))))
        else $error("checksum half not reduced modulo 65521");

    // Input back-pressure only comes from a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_chan.ready |-> (o_out_chan.valid && !o_out_chan.ready))
        else $error("input stalled without a held checksum");

endmodule

>>> hdl/adl32_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 byte lane
// Masks one byte position by the valid count and forms its weighted
// contribution to the high sum.
// ----------------------------------------------------------------------------
module adl32_lane #(
    parameter int BYTES_PER_WORD = adl32_pkg::BYTES_PER_WORD_DEF,
    parameter int LANE_IDX       = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_advance,
    input  logic [7:0]                             i_byte,
    input  logic [$clog2(BYTES_PER_WORD+1)-1:0]    i_n,
    output logic [7:0]                             o_byte,
    output logic [$clog2(BYTES_PER_WORD+1)+7:0]    o_wgt
);
    import adl32_pkg::*;

    localparam int NW = $clog2(BYTES_PER_WORD + 1);
    localparam int PW = NW + 8;

    logic          w_active;
    logic [NW-1:0] w_dist;
    logic [7:0]    w_byte;
    logic [PW-1:0] w_wgt;
    logic [7:0]    r_byte;
    logic [PW-1:0] r_wgt;

    // weight is the number of running-sum additions this byte takes part in
    assign w_active = (i_n > NW'(LANE_IDX));
    assign w_dist   = i_n - NW'(LANE_IDX);
    assign w_byte   = w_active ? i_byte : 8'h00;
    assign w_wgt    = PW'(w_dist) * PW'(w_byte);

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_byte <= w_byte;
            r_wgt  <= w_wgt;
        end
    end

    assign o_byte = r_byte;
    assign o_wgt  = r_wgt;
endmodule

>>> hdl/adl32_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 lane merge
// Sums the lane bytes and lane weights and reduces both modulo 65521.
// ----------------------------------------------------------------------------
module adl32_merge #(
    parameter int BYTES_PER_WORD = adl32_pkg::BYTES_PER_WORD_DEF
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_advance,
    input  adl32_pkg::t_ctl                                         i_ctl,
    input  logic [$clog2(BYTES_PER_WORD+1)-1:0]                     i_n,
    input  logic [BYTES_PER_WORD-1:0][7:0]                          i_bytes,
    input  logic [BYTES_PER_WORD-1:0][$clog2(BYTES_PER_WORD+1)+7:0] i_wgts,
    output adl32_pkg::t_ctl                                         o_ctl,
    output logic [$clog2(BYTES_PER_WORD+1)-1:0]                     o_n,
    output logic [adl32_pkg::HALF_W-1:0]                            o_sum_lo,
    output logic [adl32_pkg::HALF_W-1:0]                            o_sum_wt
);
    import adl32_pkg::*;

    localparam int NW = $clog2(BYTES_PER_WORD + 1);
    localparam int SW = NW + 8;
    localparam int WW = (2 * NW + 8 > 17) ? (2 * NW + 8) : 17;

    logic [SW-1:0]     w_sum;
    logic [WW-1:0]     w_wsum;
    logic [WW-1:0]     w_wsum_r1;
    t_ctl              r_ctl;
    logic [NW-1:0]     r_n;
    logic [HALF_W-1:0] r_sum_lo;
    logic [HALF_W-1:0] r_sum_wt;

    always_comb begin
        w_sum  = '0;
        w_wsum = '0;
        for (int k = 0; k < BYTES_PER_WORD; k++) begin
            w_sum  = w_sum + SW'(i_bytes[k]);
            w_wsum = w_wsum + WW'(i_wgts[k]);
        end
    end

    // weighted sum stays below three times the modulus: two subtracts
    assign w_wsum_r1 = (w_wsum >= WW'(ADLER_MOD)) ? (w_wsum - WW'(ADLER_MOD)) : w_wsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_advance) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_n      <= i_n;
            r_sum_lo <= mod_once(17'(w_sum));
            r_sum_wt <= mod_once(w_wsum_r1[16:0]);
        end
    end

    assign o_ctl    = r_ctl;
    assign o_n      = r_n;
    assign o_sum_lo = r_sum_lo;
    assign o_sum_wt = r_sum_wt;
endmodule

>>> hdl/adl32_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 accumulator
// Holds the running sums and start value, folds in one merged word per cycle
// while advancing, and registers the checksum on the closing transaction.
// ----------------------------------------------------------------------------
module adl32_accum #(
    parameter int BYTES_PER_WORD = adl32_pkg::BYTES_PER_WORD_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic                                i_cfg_wr_en,
    input  logic [adl32_pkg::CHECKSUM_W-1:0]    i_cfg_wr_data,
    input  adl32_pkg::t_ctl                     i_ctl,
    input  logic [$clog2(BYTES_PER_WORD+1)-1:0] i_n,
    input  logic [adl32_pkg::HALF_W-1:0]        i_sum_lo,
    input  logic [adl32_pkg::HALF_W-1:0]        i_sum_wt,
    output logic                                o_valid,
    output logic [adl32_pkg::CHECKSUM_W-1:0]    o_checksum
);
    import adl32_pkg::*;

    localparam int NW = $clog2(BYTES_PER_WORD + 1);
    localparam int PW = NW + 16;
    localparam int HT = NW + 18;

    logic [HALF_W-1:0]     r_start_lo;
    logic [HALF_W-1:0]     r_start_hi;
    logic [HALF_W-1:0]     r_low;
    logic [HALF_W-1:0]     r_high;
    logic                  r_valid;
    logic [CHECKSUM_W-1:0] r_checksum;

    logic [HALF_W-1:0]     w_base_lo;
    logic [HALF_W-1:0]     w_base_hi;
    logic [HALF_W-1:0]     w_low_new;
    logic [PW-1:0]         w_prod;
    logic [HT-1:0]         w_high_t;
    logic [16:0]           w_fold;
    logic [HALF_W-1:0]     w_high_new;
    logic                  w_take;

    assign w_take    = i_advance && i_ctl.valid;
    assign w_base_lo = i_ctl.first ? r_start_lo : r_low;
    assign w_base_hi = i_ctl.first ? r_start_hi : r_high;

    assign w_low_new = mod_once({1'b0, w_base_lo} + {1'b0, i_sum_lo});

    // high gains n copies of the old low sum plus the weighted byte sum
    assign w_prod     = PW'(i_n) * PW'(w_base_lo);
    assign w_high_t   = HT'(w_base_hi) + HT'(w_prod) + HT'(i_sum_wt);
    assign w_fold     = 17'(w_high_t[HT-1:16]) * 17'(ADLER_FOLD) + 17'(w_high_t[15:0]);
    assign w_high_new = mod_once(w_fold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_lo <= START_LO_RST;
            r_start_hi <= START_HI_RST;
            r_low      <= START_LO_RST;
            r_high     <= START_HI_RST;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_lo <= mod_once(17'(i_cfg_wr_data[15:0]));
                r_start_hi <= mod_once(17'(i_cfg_wr_data[31:16]));
            end
            if (w_take) begin
                r_low  <= w_low_new;
                r_high <= w_high_new;
            end
            if (i_advance) begin
                r_valid <= i_ctl.valid && i_ctl.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_ctl.last) begin
            r_checksum <= {w_high_new, w_low_new};
        end
    end

    assign o_valid    = r_valid;
    assign o_checksum = r_checksum;
endmodule

>>> verif/adler32_stream_checksum_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 stream checksum testbench
// Sends word transactions with random framing, byte counts and idle gaps on
// both channels. An in-bench Adler-32 model predicts every checksum, and each
// checksum that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module adler32_stream_checksum_top_tb;
    import adl32_pkg::*;

    localparam int          CLK_HALF      = 2;
    localparam int          RESET_CYCLES  = 7;
    // The pipeline is three stages deep; allow a margin on top of that.
    localparam int          SETTLE_CYCLES = 10;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          WORD_BYTES    = BYTES_PER_WORD_DEF;
    localparam int          HOLD_OFF_LEN  = 300;
    localparam logic [16:0] MODULUS       = 17'd65521;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CHECKSUM_W-1:0] i_cfg_wr_data;

    adl32_in_if  in_chan ();
    adl32_out_if out_chan ();

    adler32_stream_checksum_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_chan     (in_chan),
        .o_out_chan    (out_chan)
    );

    // Model copy of the start value register and the two running sums
    logic [31:0]     model_start;
    logic [15:0]     model_low;
    logic [15:0]     model_high;
    logic [31:0]     pending_checksums [$];

    int error_count = 0;
    int cycle_count = 0;
    // Idling switch shared by both channels; clear it for back-to-back stretches
    bit idle_on     = 1'b1;
    // Receiver hold-off and short stall counters, counted down by the receiver
    int hold_left   = 0;
    int stall_left  = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Adler-32 model
    // ------------------------------------------------------------------------
    // One conditional subtract is enough: both operands are already below the
    // modulus, or the loaded half is below 2^16.
    function automatic logic [15:0] wrap_mod(input logic [16:0] v);
        logic [16:0] d;
        d = v - MODULUS;
        return (v >= MODULUS) ? d[15:0] : v[15:0];
    endfunction

    // Fold one accepted transaction into the running sums
    task automatic absorb_word(input logic [DATA_W-1:0] word,
                               input logic [COUNT_W-1:0] count,
                               input logic reload);
        int taken;
        logic [7:0] b;
        taken = (count > WORD_BYTES) ? WORD_BYTES : int'(count);
        if (reload) begin
            model_low  = wrap_mod({1'b0, model_start[15:0]});
            model_high = wrap_mod({1'b0, model_start[31:16]});
        end
        for (int i = 0; i < taken; i++) begin
            b          = (i < DATA_BYTES) ? word[8*i +: 8] : 8'h00;
            model_low  = wrap_mod({1'b0, model_low} + 17'(b));
            model_high = wrap_mod({1'b0, model_high} + {1'b0, model_low});
        end
    endtask

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 15);
    endfunction

    // Full words dominate; all-ones words push the sums across the modulus
    function automatic logic [DATA_W-1:0] random_word();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r < 3)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Include empty words and counts past the word width now and then
    function automatic logic [COUNT_W-1:0] random_count();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return COUNT_W'(WORD_BYTES);
        if (r < 85)
            return COUNT_W'($urandom_range(WORD_BYTES - 1, 1));
        if (r < 93)
            return '0;
        return COUNT_W'($urandom_range(15, WORD_BYTES + 1));
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Offer one transaction, hold it until accepted, then predict and idle.
    // Valid is left high so a following transaction goes out back to back.
    task automatic send_word(input logic [DATA_W-1:0] word,
                             input logic [COUNT_W-1:0] count,
                             input logic is_first,
                             input logic is_last);
        int gap;
        @(negedge i_clk);
        in_chan.valid      = 1'b1;
        in_chan.data_word  = word;
        in_chan.byte_count = count;
        in_chan.first      = is_first;
        in_chan.last       = is_last;
        do
            @(posedge i_clk);
        while (!in_chan.ready);
        absorb_word(word, count, is_first);
        if (is_last)
            pending_checksums.push_back({model_high, model_low});
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_chan.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Random message; now and then restart it mid-way with a stray first
    task automatic send_message(input int len, input bit with_first, input bit with_last);
        logic f;
        for (int i = 0; i < len; i++) begin
            f = (i == 0 && with_first) || ($urandom_range(30) == 0);
            send_word(random_word(), random_count(), f, with_last && i == len - 1);
        end
    endtask

    // Drop valid and wait until every predicted checksum has come out. Items
    // without last can still be in flight, so let the pipeline settle too.
    task automatic wait_for_results();
        @(negedge i_clk);
        in_chan.valid = 1'b0;
        while (pending_checksums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the start value register with the block idle
    task automatic write_start_value(input logic [31:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        model_start   = value;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Last without any first: sums carry on from their reset values, then
    // from the previous message
    task automatic test_reset_sums();
        send_word(64'h0000_0000_0003_0201, 4'd3, 1'b0, 1'b1);
        send_word(64'h0000_0000_0000_00ff, 4'd1, 1'b0, 1'b1);
    endtask

    // Empty word with first, short and full counts, saturated counts, and a
    // first-and-last transaction that takes no bytes
    task automatic test_byte_counts();
        send_word('1,                      4'd0,  1'b1, 1'b0);
        send_word(64'h0807_0605_0403_0201, 4'd1,  1'b0, 1'b0);
        send_word(64'h8877_6655_4433_2211, 4'd7,  1'b0, 1'b0);
        send_word('1,                      4'd8,  1'b0, 1'b0);
        send_word(64'hdead_beef_cafe_f00d, 4'd9,  1'b0, 1'b0);
        send_word('1,                      4'd15, 1'b0, 1'b1);
        send_word('1,                      4'd0,  1'b1, 1'b1);
    endtask

    // All-ones and all-zero words
    task automatic test_data_extremes();
        send_word('1, 4'd8, 1'b1, 1'b0);
        send_word('1, 4'd8, 1'b0, 1'b0);
        send_word('1, 4'd8, 1'b0, 1'b1);
        send_word('0, 4'd8, 1'b1, 1'b1);
    endtask

    // Start value extremes, including halves at and above the modulus
    task automatic test_start_values();
        logic [31:0] corner_starts [5];
        corner_starts[0] = 32'h0000_0000;
        corner_starts[1] = 32'hffff_ffff;
        corner_starts[2] = 32'hfff1_fff1;
        corner_starts[3] = 32'hfff0_fff0;
        corner_starts[4] = 32'h0001_fff2;
        foreach (corner_starts[i]) begin
            write_start_value(corner_starts[i]);
            send_word('1, 4'd8, 1'b1, 1'b1);
        end
    endtask

    // Hold the receiver off for a long stretch while single-transaction
    // messages go in back to back, so the pipeline fills and input stalls
    task automatic test_backpressure();
        wait_for_results();
        idle_on   = 1'b0;
        hold_left = HOLD_OFF_LEN;
        for (int i = 0; i < 30; i++)
            send_word(random_word(), random_count(), 1'b1, 1'b1);
        wait_for_results();
        idle_on   = 1'b1;
    endtask

    // Mostly well-framed messages with random content over several start
    // values; some lack a first or a last, and one phase runs without idling
    task automatic test_random_messages();
        int sent;
        int len;
        logic [31:0] start_pick;
        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                case ($urandom_range(3))
                    0:       start_pick = 32'hffff_ffff;
                    1:       start_pick = 32'h0000_0001;
                    default: start_pick = $urandom;
                endcase
                write_start_value(start_pick);
            end
            idle_on = (phase != 2);
            while (sent < RANDOM_ITEMS * (phase + 1) / 6) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                send_message(len, $urandom_range(9) != 0, $urandom_range(19) != 0);
                sent += len;
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: long hold-off first, then short random stalls
    // ------------------------------------------------------------------------
    initial begin
        out_chan.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_chan.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_chan.ready = 1'b0;
                stall_left--;
            end else begin
                out_chan.ready = 1'b1;
                if ($urandom_range(4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each accepted checksum with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        logic [31:0] want;
        if (i_rst_n && out_chan.valid && out_chan.ready) begin
            if (pending_checksums.size() == 0) begin
                $error("checksum: expected none, actual %08h", out_chan.checksum);
                error_count++;
            end else begin
                want = pending_checksums.pop_front();
                if (out_chan.checksum !== want) begin
                    $error("checksum: expected %08h, actual %08h", want, out_chan.checksum);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if it hangs
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        in_chan.valid      = 1'b0;
        in_chan.data_word  = '0;
        in_chan.byte_count = '0;
        in_chan.first      = 1'b0;
        in_chan.last       = 1'b0;
        model_start        = 32'd1;
        model_low          = 16'd1;
        model_high         = 16'd0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_sums();
        test_byte_counts();
        test_data_extremes();
        test_start_values();
        test_backpressure();
        test_random_messages();

        wait_for_results();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
